// ===== design/brdq_pkg.sv =====
package brdq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CFG_W  = 5;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_TAKE   = 2'd1,
    CMD_POP    = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RD_HEAD = 2'd0,
    RD_BACK = 2'd1,
    RD_IDX  = 2'd2,
    RD_NEXT = 2'd3
  } rd_sel_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] item;
    status_t           status;
    logic [CNT_W-1:0]  count;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    push;
    logic    take;
    logic    pop;
    logic    rm_done;
    logic    scan_init;
    logic    scan_next;
    logic    shift_init;
    logic    shift_step;
    logic    emit;
    status_t st;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t cmd;
    logic full;
    logic empty;
    logic hit;
    logic rem_one;
    logic rem_zero;
  } stat_t;

  function automatic logic [PTR_W-1:0] ptr_fwd(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] n;
    logic [PTR_W-1:0] r;
    n = CNT_W'(p) + CNT_W'(1);
    if (n >= c || n >= CNT_W'(DEPTH)) begin
      r = '0;
    end else begin
      r = n[PTR_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_back(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] m;
    logic [PTR_W-1:0] r;
    m = c - CNT_W'(1);
    if (p == '0 || CNT_W'(p) > c) begin
      r = m[PTR_W-1:0];
    end else begin
      r = p - PTR_W'(1);
    end
    return r;
  endfunction

endpackage

// ===== design/brdq_ctrl.sv =====
module brdq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  brdq_pkg::cmd_t  cmd,
  input  brdq_pkg::stat_t stat,
  output brdq_pkg::ctl_t  ctl,
  output logic            busy
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_EXEC     = 6'b000010,
    S_SCAN_RD  = 6'b000100,
    S_SCAN_CMP = 6'b001000,
    S_SHIFT_RD = 6'b010000,
    S_SHIFT_WR = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    ctl        = '0;
    ctl.rd_sel = brdq_pkg::RD_HEAD;
    ctl.st     = brdq_pkg::ST_OK;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        // prefetch the word a take or pop will need
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = (cmd == brdq_pkg::CMD_POP) ? brdq_pkg::RD_BACK : brdq_pkg::RD_HEAD;
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.cmd)
          brdq_pkg::CMD_PUSH: begin
            ctl.emit   = 1'b1;
            state_next = S_IDLE;
            if (stat.full) begin
              ctl.st = brdq_pkg::ST_FULL;
            end else begin
              ctl.push = 1'b1;
            end
          end
          brdq_pkg::CMD_TAKE: begin
            ctl.emit   = 1'b1;
            state_next = S_IDLE;
            if (stat.empty) begin
              ctl.st = brdq_pkg::ST_EMPTY;
            end else begin
              ctl.take = 1'b1;
            end
          end
          brdq_pkg::CMD_POP: begin
            ctl.emit   = 1'b1;
            state_next = S_IDLE;
            if (stat.empty) begin
              ctl.st = brdq_pkg::ST_EMPTY;
            end else begin
              ctl.pop = 1'b1;
            end
          end
          brdq_pkg::CMD_REMOVE: begin
            if (stat.empty) begin
              ctl.emit   = 1'b1;
              ctl.st     = brdq_pkg::ST_NOTFOUND;
              state_next = S_IDLE;
            end else begin
              ctl.scan_init = 1'b1;
              state_next    = S_SCAN_RD;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_SCAN_RD: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = brdq_pkg::RD_IDX;
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (stat.hit) begin
          ctl.shift_init = 1'b1;
          state_next     = S_SHIFT_RD;
        end else if (stat.rem_one) begin
          ctl.emit   = 1'b1;
          ctl.st     = brdq_pkg::ST_NOTFOUND;
          state_next = S_IDLE;
        end else begin
          ctl.scan_next = 1'b1;
          state_next    = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        if (stat.rem_zero) begin
          ctl.rm_done = 1'b1;
          ctl.emit    = 1'b1;
          state_next  = S_IDLE;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = brdq_pkg::RD_NEXT;
          state_next = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        // move the next entry one slot toward the head
        ctl.shift_step = 1'b1;
        state_next     = S_SHIFT_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== design/brdq_dp.sv =====
module brdq_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  brdq_pkg::req_t                req,
  input  logic                          cfg_we,
  input  logic [brdq_pkg::CFG_W-1:0]    cfg_data,
  input  brdq_pkg::ctl_t                ctl,
  output brdq_pkg::stat_t               stat,
  output logic                          done,
  output brdq_pkg::rsp_t                rsp
);

  logic [brdq_pkg::CNT_W-1:0]  cap, occ, occ_next, rem, cap_wr;
  logic [brdq_pkg::PTR_W-1:0]  head, tail, idx;
  logic [brdq_pkg::PTR_W-1:0]  head_fwd, tail_back, idx_fwd;
  logic [brdq_pkg::PTR_W-1:0]  rd_addr, wr_addr;
  logic [brdq_pkg::DATA_W-1:0] key, rd_data, wr_data;
  logic                        wr_en;
  brdq_pkg::cmd_t              cmd_q;
  logic [brdq_pkg::DATA_W-1:0] mem [brdq_pkg::DEPTH];

  assign head_fwd  = brdq_pkg::ptr_fwd(head, cap);
  assign tail_back = brdq_pkg::ptr_back(tail, cap);
  assign idx_fwd   = brdq_pkg::ptr_fwd(idx, cap);

  always_comb begin
    cap_wr = brdq_pkg::CNT_W'(cfg_data);
    if (cap_wr == '0) begin
      cap_wr = brdq_pkg::CNT_W'(1);
    end else if (cap_wr > brdq_pkg::CNT_W'(brdq_pkg::DEPTH)) begin
      cap_wr = brdq_pkg::CNT_W'(brdq_pkg::DEPTH);
    end
  end

  always_comb begin
    occ_next = occ;
    if (ctl.push) begin
      occ_next = occ + brdq_pkg::CNT_W'(1);
    end else if (ctl.take || ctl.pop || ctl.rm_done) begin
      occ_next = occ - brdq_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    unique case (ctl.rd_sel)
      brdq_pkg::RD_HEAD: rd_addr = head;
      brdq_pkg::RD_BACK: rd_addr = tail_back;
      brdq_pkg::RD_IDX:  rd_addr = idx;
      brdq_pkg::RD_NEXT: rd_addr = idx_fwd;
      default:           rd_addr = head;
    endcase
  end

  assign wr_en   = ctl.push || ctl.shift_step;
  assign wr_addr = ctl.push ? tail : idx;
  assign wr_data = ctl.push ? key : rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap  <= brdq_pkg::CNT_W'(brdq_pkg::DEPTH);
      head <= '0;
      tail <= '0;
      occ  <= '0;
      done <= 1'b0;
    end else begin
      done <= ctl.emit;
      if (cfg_we) begin
        // new capacity empties the ring
        cap  <= cap_wr;
        head <= '0;
        tail <= '0;
        occ  <= '0;
      end else begin
        if (ctl.push) begin
          tail <= brdq_pkg::ptr_fwd(tail, cap);
        end
        if (ctl.take) begin
          head <= head_fwd;
        end
        if (ctl.pop || ctl.rm_done) begin
          tail <= tail_back;
        end
        occ <= occ_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= req.cmd;
      key   <= req.value;
    end
    if (ctl.scan_init) begin
      idx <= head;
      rem <= occ;
    end else if (ctl.scan_next || ctl.shift_step) begin
      idx <= idx_fwd;
      rem <= rem - brdq_pkg::CNT_W'(1);
    end else if (ctl.shift_init) begin
      rem <= rem - brdq_pkg::CNT_W'(1);
    end
    if (ctl.emit) begin
      rsp.item   <= (ctl.take || ctl.pop) ? rd_data : '0;
      rsp.status <= ctl.st;
      rsp.count  <= occ_next;
    end
  end

  assign stat.cmd      = cmd_q;
  assign stat.full     = (occ >= cap);
  assign stat.empty    = (occ == '0);
  assign stat.hit      = (rd_data == key);
  assign stat.rem_one  = (rem == brdq_pkg::CNT_W'(1));
  assign stat.rem_zero = (rem == '0);

endmodule

// ===== design/bounded_ring_deque_with_remove.sv =====
// Channel   Transfer when        Payload
// command   start && !busy       req  (cmd, value)
// result    done                 rsp  (item, status, count)
// config    cfg_we               cfg_data (capacity)
//
// Push, take and pop: each is decided in the single S_EXEC state, then the block is idle again.
// Remove: one memory read per compared entry and a read plus write per moved
// entry behind a matching key; when the key is absent, every entry is compared.
// Reset empties the deque and sets capacity to its maximum; no clearing pass.
// done pulses one cycle per command; the result must be taken in that cycle.
module bounded_ring_deque_with_remove (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  brdq_pkg::req_t             req,
  input  logic                       cfg_we,
  input  logic [brdq_pkg::CFG_W-1:0] cfg_data,
  output logic                       done,
  output brdq_pkg::rsp_t             rsp
);

  brdq_pkg::ctl_t  ctl;
  brdq_pkg::stat_t stat;

  brdq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (req.cmd),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  brdq_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .ctl      (ctl),
    .stat     (stat),
    .done     (done),
    .rsp      (rsp)
  );

endmodule

// ===== design/brdq_chk.sv =====
module brdq_chk (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input brdq_pkg::rsp_t rsp
);

  // an accepted command raises busy in the cycle after it is accepted
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a command in flight");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> rsp.count <= brdq_pkg::CNT_W'(brdq_pkg::DEPTH))
    else $error("count exceeds store depth");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status == brdq_pkg::ST_EMPTY |-> rsp.count == '0)
    else $error("empty rejection with nonzero count");

  a_item_zero: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status != brdq_pkg::ST_OK |-> rsp.item == '0)
    else $error("rejected command returned a word");

endmodule

bind bounded_ring_deque_with_remove brdq_chk u_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);
